### hw/rtl/lcpid_pkg.sv
// Shared types and constants for the predictive image decoder.
// Used by lcpid_out_skid and lut_coded_predictive_image_decoder.
// No dependencies.
package lcpid_pkg;

    localparam int CFG_W_BITS   = 11;
    localparam int CFG_H_BITS   = 11;
    localparam int CFG_HDR_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEADER_LENGTH = 2'd2;

    localparam logic [CFG_W_BITS-1:0]   CFG_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0]   CFG_HEIGHT_RESET = 11'd1024;
    localparam logic [CFG_HDR_BITS-1:0] CFG_HDR_RESET    = 16'd1024;

    localparam logic [1:0] CODE_BYTE1 = 2'd0;
    localparam logic [1:0] CODE_BYTE2 = 2'd1;
    localparam logic [1:0] CODE_BYTE4 = 2'd2;
    localparam logic [1:0] CODE_BAD   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_TABLE,
        PH_RAW,
        PH_DIFF,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        last_pixel;
        logic        bad_code;
    } t_result;

endpackage

### hw/rtl/lcpid_out_skid.sv
// Two-entry output register with skid stage for decoded pixels.
// Depends on lcpid_pkg (t_result).
module lcpid_out_skid
    import lcpid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid) begin
                r_out_valid <= i_push;
            end else if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || (pop && !r_skid_valid)) begin
            r_out <= i_push_data;
        end else if (pop) begin
            r_out <= r_skid;
        end
        if (r_out_valid && !pop && i_push) begin
            r_skid <= i_push_data;
        end
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("request pushed into a full output stage");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

endmodule

### hw/rtl/lut_coded_predictive_image_decoder.sv
// Byte-stream decoder for code-table compressed projection images: the top level.
// Depends on lcpid_pkg and lcpid_out_skid.
//
// The block takes one file byte per cycle while its output has room and gives at most one
// 32-bit pixel per byte; a pixel is registered in the output stage, or in its skid entry
// while the output is held. Each byte passes once through the decode logic (byte assembly,
// sign extension and the left + up + diff - upleft add) between the state registers
// and the output stage. The size-code table sits in an on-chip memory of CODE_STORE_DEPTH
// bytes and the previous row in a memory of MAX_WIDTH + 1 pixels; both are read ahead, so
// these reads never stall the stream. Neither memory is cleared after reset. Geometry and
// header length are sampled on the byte flagged as frame start; a bad size code gives one
// result with tuser set and the block then drops bytes until the next frame start.
module lut_coded_predictive_image_decoder
    import lcpid_pkg::*;
#(
    parameter int MAX_WIDTH        = 1024,
    parameter int MAX_HEIGHT       = 1024,
    parameter int CODE_STORE_DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [7:0]               i_s_tdata,   // [7:0] data_byte
    input  logic                     i_s_tuser,   // frame_start
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [31:0]              o_m_tdata,   // [31:0] pixel_value
    output logic                     o_m_tlast,   // last_pixel
    output logic                     o_m_tuser    // bad_code
);

    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int HB   = $clog2(MAX_HEIGHT + 1);
    localparam int PB   = WB + HB;
    localparam int TB   = PB - 2;
    localparam int CB   = (TB > CFG_HDR_BITS) ? TB : CFG_HDR_BITS;
    localparam int CA   = $clog2(CODE_STORE_DEPTH);
    localparam int HIST_DEPTH = MAX_WIDTH + 1;

    logic [CFG_W_BITS-1:0]   r_cfg_w;
    logic [CFG_H_BITS-1:0]   r_cfg_h;
    logic [CFG_HDR_BITS-1:0] r_cfg_hdr;

    t_phase                  r_phase, n_phase;
    logic [CB-1:0]           r_cnt, n_cnt;
    logic [PB-1:0]           r_pix, n_pix;
    logic [PB-1:0]           r_k, n_k;
    logic [WB-1:0]           r_ring, n_ring;
    logic [1:0]              r_bidx, n_bidx;
    logic [1:0]              r_code, n_code;
    logic [31:0]             r_partial, n_partial;
    logic [31:0]             r_left, n_left;
    logic [31:0]             r_upleft, n_upleft;
    logic [31:0]             r_up;
    logic [7:0]              r_code_rd;
    logic                    r_code_oob;

    logic [WB-1:0]           r_w;
    logic [CFG_HDR_BITS-1:0] r_hdr;
    logic [TB-1:0]           r_table;
    logic [PB-1:0]           r_total_m1;

    logic [7:0]  code_mem [CODE_STORE_DEPTH];
    logic [31:0] hist_mem [HIST_DEPTH];

    logic          acc, start;
    logic [WB-1:0] c_w;
    logic [HB-1:0] c_h;
    logic [PB-1:0] c_total;
    logic [TB-1:0] c_table;
    t_phase        c_start_phase;

    t_phase                  e_phase;
    logic [CB-1:0]           e_cnt;
    logic [PB-1:0]           e_pix, e_k;
    logic [WB-1:0]           e_ring, e_w;
    logic [CFG_HDR_BITS-1:0] e_hdr;
    logic [TB-1:0]           e_table;
    logic [PB-1:0]           e_total_m1;
    logic [1:0]              e_bidx;
    logic [31:0]             e_partial;

    logic [31:0]   word, d_ext, v_pred;
    logic [1:0]    code_now;
    logic          hdr_done, tbl_done, raw_last, diff_first, diff_done, diff_last, bad;
    logic          hist_we, code_we;
    logic [WB-1:0] ring_adv, up_addr;
    logic [TB-1:0] n_idx;
    logic          push;
    t_result       push_data;

    assign acc   = i_s_tvalid && o_s_tready;
    assign start = acc && i_s_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= CFG_WIDTH_RESET;
            r_cfg_h   <= CFG_HEIGHT_RESET;
            r_cfg_hdr <= CFG_HDR_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_cfg_w   <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT:  r_cfg_h   <= i_cfg_data[CFG_H_BITS-1:0];
                CFG_HEADER_LENGTH: r_cfg_hdr <= i_cfg_data[CFG_HDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w < CFG_W_BITS'(2)) begin
            c_w = WB'(2);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            c_w = WB'(MAX_WIDTH);
        end else begin
            c_w = WB'(r_cfg_w);
        end
        if (r_cfg_h < CFG_H_BITS'(2)) begin
            c_h = HB'(2);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            c_h = HB'(MAX_HEIGHT);
        end else begin
            c_h = HB'(r_cfg_h);
        end
        c_total = PB'(c_w) * PB'(c_h);
        c_table = TB'((c_total - PB'(c_w)) >> 2);
        if (r_cfg_hdr != '0) begin
            c_start_phase = PH_HEADER;
        end else if (c_table != '0) begin
            c_start_phase = PH_TABLE;
        end else begin
            c_start_phase = PH_RAW;
        end
    end

    always_comb begin
        e_phase    = start ? c_start_phase : r_phase;
        e_cnt      = start ? '0 : r_cnt;
        e_pix      = start ? '0 : r_pix;
        e_k        = start ? '0 : r_k;
        e_ring     = start ? '0 : r_ring;
        e_w        = start ? c_w : r_w;
        e_hdr      = start ? r_cfg_hdr : r_hdr;
        e_table    = start ? c_table : r_table;
        e_total_m1 = start ? (c_total - PB'(1)) : r_total_m1;
        e_bidx     = start ? '0 : r_bidx;
        e_partial  = start ? '0 : r_partial;
    end

    always_comb begin
        case (e_bidx)
            2'd0:    word = e_partial | {24'd0, i_s_tdata};
            2'd1:    word = e_partial | {16'd0, i_s_tdata, 8'd0};
            2'd2:    word = e_partial | {8'd0, i_s_tdata, 16'd0};
            default: word = e_partial | {i_s_tdata, 24'd0};
        endcase

        hdr_done   = (32'(e_cnt) + 32'd1) == 32'(e_hdr);
        tbl_done   = (32'(e_cnt) + 32'd1) == 32'(e_table);
        raw_last   = e_pix == PB'(e_w);
        diff_first = e_bidx == 2'd0;
        code_now   = diff_first ? (r_code_oob ? CODE_BYTE1 : r_code_rd[2*e_k[1:0] +: 2])
                                : r_code;
        bad        = diff_first && (code_now == CODE_BAD);
        case (code_now)
            CODE_BYTE1: begin
                diff_done = e_bidx == 2'd0;
                d_ext     = {{24{word[7]}}, word[7:0]};
            end
            CODE_BYTE2: begin
                diff_done = e_bidx == 2'd1;
                d_ext     = {{16{word[15]}}, word[15:0]};
            end
            default: begin
                diff_done = e_bidx == 2'd3;
                d_ext     = word;
            end
        endcase
        diff_last = e_pix == e_total_m1;
        v_pred    = r_left + r_up + d_ext - r_upleft;
        ring_adv  = (e_ring == e_w) ? '0 : e_ring + WB'(1);
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (acc) begin
            unique case (e_phase)
                PH_HEADER: begin
                    if (hdr_done) begin
                        n_phase = (e_table == '0) ? PH_RAW : PH_TABLE;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_TABLE: n_phase = tbl_done ? PH_RAW : PH_TABLE;
                PH_RAW:   n_phase = (e_bidx == 2'd3 && raw_last) ? PH_DIFF : PH_RAW;
                PH_DIFF: begin
                    if (bad || (diff_done && diff_last)) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_phase = PH_DIFF;
                    end
                end
                PH_IDLE:  n_phase = PH_IDLE;
                PH_STOP:  n_phase = PH_STOP;
                default:  n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_cnt     = r_cnt;
        n_pix     = r_pix;
        n_k       = r_k;
        n_ring    = r_ring;
        n_bidx    = r_bidx;
        n_code    = r_code;
        n_partial = r_partial;
        n_left    = r_left;
        n_upleft  = r_upleft;
        hist_we   = 1'b0;
        code_we   = 1'b0;
        push      = 1'b0;
        push_data = '0;
        if (acc) begin
            n_cnt     = e_cnt;
            n_pix     = e_pix;
            n_k       = e_k;
            n_ring    = e_ring;
            n_bidx    = e_bidx;
            n_partial = e_partial;
            unique case (e_phase)
                PH_HEADER: begin
                    n_cnt = hdr_done ? '0 : e_cnt + CB'(1);
                    if (hdr_done) begin
                        n_bidx    = '0;
                        n_partial = '0;
                    end
                end
                PH_TABLE: begin
                    code_we   = 32'(e_cnt) < CODE_STORE_DEPTH;
                    n_cnt     = e_cnt + CB'(1);
                    n_bidx    = '0;
                    n_partial = '0;
                end
                PH_RAW: begin
                    if (e_bidx == 2'd3) begin
                        push      = 1'b1;
                        push_data = '{pixel_value: word, last_pixel: 1'b0, bad_code: 1'b0};
                        hist_we   = 1'b1;
                        n_ring    = ring_adv;
                        n_pix     = e_pix + PB'(1);
                        n_left    = word;
                        n_bidx    = '0;
                        n_partial = '0;
                        if (e_pix == '0) begin
                            n_upleft = word;
                        end
                    end else begin
                        n_bidx    = e_bidx + 2'd1;
                        n_partial = word;
                    end
                end
                PH_DIFF: begin
                    if (bad) begin
                        push      = 1'b1;
                        push_data = '{pixel_value: 32'd0, last_pixel: 1'b1, bad_code: 1'b1};
                    end else if (diff_done) begin
                        push      = 1'b1;
                        push_data = '{pixel_value: v_pred, last_pixel: diff_last,
                                      bad_code: 1'b0};
                        hist_we   = 1'b1;
                        n_ring    = ring_adv;
                        n_pix     = e_pix + PB'(1);
                        n_k       = e_k + PB'(1);
                        n_left    = v_pred;
                        n_upleft  = r_up;
                        n_bidx    = '0;
                        n_partial = '0;
                    end else begin
                        n_code    = code_now;
                        n_bidx    = e_bidx + 2'd1;
                        n_partial = word;
                    end
                end
                PH_IDLE: ;
                PH_STOP: ;
                default: ;
            endcase
        end
        n_idx   = n_k[PB-1:2];
        up_addr = (n_ring == e_w) ? '0 : n_ring + WB'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_pix   <= '0;
            r_k     <= '0;
            r_ring  <= '0;
            r_bidx  <= '0;
            r_code  <= CODE_BYTE1;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_pix   <= n_pix;
            r_k     <= n_k;
            r_ring  <= n_ring;
            r_bidx  <= n_bidx;
            r_code  <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_partial  <= n_partial;
        r_left     <= n_left;
        r_upleft   <= n_upleft;
        r_w        <= e_w;
        r_hdr      <= e_hdr;
        r_table    <= e_table;
        r_total_m1 <= e_total_m1;
        r_code_oob <= (32'(n_idx) >= 32'(e_table)) || (32'(n_idx) >= CODE_STORE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (code_we) begin
            code_mem[CA'(e_cnt)] <= i_s_tdata;
        end
        r_code_rd <= code_mem[CA'(n_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[e_ring] <= push_data.pixel_value;
        end
        r_up <= hist_mem[up_addr];
    end

    t_result out_data;

    lcpid_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .o_data      (out_data),
        .i_ready     (i_m_tready)
    );

    assign o_m_tdata = out_data.pixel_value;
    assign o_m_tlast = out_data.last_pixel;
    assign o_m_tuser = out_data.bad_code;

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && push_data.last_pixel |=> r_phase == PH_STOP)
        else $error("final or bad pixel did not stop the frame");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOP && !start |=> r_phase == PH_STOP)
        else $error("left stop without a frame start");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE && !start |-> !push)
        else $error("result produced before any frame start");

    a_short_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DIFF && r_bidx != 2'd0 |-> r_code != CODE_BYTE1 && r_code != CODE_BAD)
        else $error("partial difference held under a one-byte or bad code");

endmodule
